FILE: rtl/core/htbd_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the Huffman tree walk decoder.
// Self-contained; used by the top level and the checker in rtl/core.
package htbd_pkg;

    localparam int NODE_COUNT = 512;
    localparam int SYMBOL_BITS = 8;
    localparam int IDX_W = 9;
    localparam int NODE_AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int BYTE_W = 8;
    localparam int CNT_W = 4;
    localparam int ENTRY_W = 1 + SYMBOL_BITS + 2 * IDX_W;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DECODE = 1'b1;
    localparam logic STATUS_SYMBOL = 1'b0;
    localparam logic STATUS_DAMAGED = 1'b1;

    typedef struct packed {
        logic                   leaf;
        logic [SYMBOL_BITS-1:0] symbol;
        logic [IDX_W-1:0]       zero_child;
        logic [IDX_W-1:0]       one_child;
    } t_node;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] symbol;
        logic                   status;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_ADDR,
        S_TEST,
        S_END,
        S_FLUSH
    } t_state;

    function automatic logic in_table(input logic [IDX_W-1:0] idx);
        return {1'b0, idx} < (IDX_W + 1)'(NODE_COUNT);
    endfunction

endpackage

FILE: rtl/core/htbd_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module htbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/core/huffman_tree_bit_decoder_top.sv
`timescale 1ns / 1ps
// Huffman tree walk decoder: node table RAM, bit shifter and walk sequencer.
// Depends on htbd_pkg and htbd_ram.
//
//   Slave stream: tuser selects the word kind. A load word (tuser 0) writes
//   one node table entry. A decode word (tuser 1) carries a coded byte and a
//   bit count; tlast marks the final byte of a stream.
//   Master stream: one word per decoded symbol, tuser 1 flags damaged data
//   (stream ended mid-codeword), tlast marks the last word of an input.
//   Config channel: writes the root index and restarts the walk there.
//   The byte leaves a shift register one bit at a time; each bit costs one
//   dependent table read (S_ADDR, S_TEST), plus a fetch of the current node
//   (S_FETCH, S_LOAD) when it is not held (after a leaf, a root write or a
//   load of it). Closing runs through S_END and S_FLUSH back to S_IDLE. A
//   load word is taken every cycle while no config write is offered, the
//   next decode word only once the walk is back in S_IDLE. A symbol waits
//   for the next result or the close.
//   Reset puts the walk and root at entry 0; the table keeps its contents
//   and must be loaded before decoding. One output register and one pending
//   result decouple the master side; the walk holds while both are full.
module huffman_tree_bit_decoder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // node_index, node_is_leaf, node_symbol, node_zero_child,
    // node_one_child, data_byte, valid_bits
    input  logic [htbd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // symbol
    output logic [htbd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // status
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [htbd_pkg::IDX_W-1:0]      i_cfg_data
);

    import htbd_pkg::*;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_root, r_pos, r_next;
    t_node                  r_cur;
    logic                   r_cur_ok;
    logic [BYTE_W-1:0]      r_bits;
    logic [CNT_W-1:0]       r_left;
    logic                   r_final;
    t_result                r_pend;
    logic                   r_pend_v;
    t_result                r_out;
    logic                   r_out_last;
    logic                   r_out_valid;
    logic                   r_rd_oor;

    logic [IDX_W-1:0]       in_node_index;
    t_node                  in_entry;
    logic [BYTE_W-1:0]      in_byte;
    logic [CNT_W-1:0]       in_count, sat_count;

    logic                   s_acc, cfg_acc, dec_acc, load_acc;
    logic                   slot_free;
    logic [ENTRY_W-1:0]     rdata;
    t_node                  nent;
    logic [IDX_W-1:0]       rd_idx, next_idx;
    logic                   more, fail;
    logic                   push, push_last;

    assign in_node_index       = s_axis_tdata[8:0];
    assign in_entry.leaf       = s_axis_tdata[9];
    assign in_entry.symbol     = s_axis_tdata[17:10];
    assign in_entry.zero_child = s_axis_tdata[26:18];
    assign in_entry.one_child  = s_axis_tdata[35:27];
    assign in_byte             = s_axis_tdata[43:36];
    assign in_count            = s_axis_tdata[47:44];
    assign sat_count = (in_count > CNT_W'(BYTE_W)) ? CNT_W'(BYTE_W) : in_count;

    assign o_cfg_ready   = (r_state == S_IDLE);
    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign dec_acc  = s_acc && (s_axis_tuser == OP_DECODE);
    assign load_acc = s_acc && (s_axis_tuser == OP_LOAD);

    assign slot_free = !r_out_valid || m_axis_tready;
    assign nent      = r_rd_oor ? '0 : t_node'(rdata);
    assign next_idx  = r_bits[BYTE_W-1] ? r_cur.one_child : r_cur.zero_child;
    assign more      = (r_left != '0);
    assign fail      = r_final && (r_pos != r_root);

    htbd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_acc && in_table(in_node_index)),
        .i_waddr (in_node_index[NODE_AW-1:0]),
        .i_wdata (in_entry),
        .i_raddr (rd_idx[NODE_AW-1:0]),
        .o_rdata (rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (dec_acc) begin
                    if (sat_count == '0) begin
                        n_state = S_END;
                    end else if (r_cur_ok) begin
                        n_state = S_ADDR;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: n_state = S_LOAD;
            S_LOAD:  n_state = S_ADDR;
            S_ADDR:  n_state = S_TEST;
            S_TEST: begin
                if (nent.leaf) begin
                    if (!(r_pend_v && !slot_free)) begin
                        n_state = more ? S_FETCH : S_END;
                    end
                end else begin
                    n_state = more ? S_ADDR : S_END;
                end
            end
            S_END: begin
                if (!(fail && r_pend_v && !slot_free)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!(r_pend_v && !slot_free)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // read address and result pushes
    always_comb begin
        rd_idx    = r_next;
        push      = 1'b0;
        push_last = 1'b0;
        unique case (r_state)
            S_FETCH: rd_idx = r_pos;
            S_ADDR:  rd_idx = next_idx;
            S_TEST:  push = nent.leaf && r_pend_v && slot_free;
            S_END:   push = fail && r_pend_v && slot_free;
            S_FLUSH: begin
                push      = r_pend_v && slot_free;
                push_last = 1'b1;
            end
            default: rd_idx = r_next;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_root      <= '0;
            r_pos       <= '0;
            r_cur_ok    <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cfg_acc) begin
                        r_root   <= i_cfg_data;
                        r_pos    <= i_cfg_data;
                        r_cur_ok <= 1'b0;
                    end else if (load_acc && in_node_index == r_pos) begin
                        r_cur_ok <= 1'b0;
                    end
                end
                S_LOAD: r_cur_ok <= 1'b1;
                S_TEST: begin
                    if (nent.leaf) begin
                        if (!(r_pend_v && !slot_free)) begin
                            // symbol found: park it and restart at the root
                            r_pend_v <= 1'b1;
                            r_pos    <= r_root;
                            r_cur_ok <= 1'b0;
                        end
                    end else begin
                        r_pos    <= r_next;
                        r_cur_ok <= 1'b1;
                    end
                end
                S_END: begin
                    if (fail && !(r_pend_v && !slot_free)) begin
                        r_pend_v <= 1'b1;
                        r_pos    <= r_root;
                        r_cur_ok <= 1'b0;
                    end
                end
                S_FLUSH: begin
                    if (slot_free) begin
                        r_pend_v <= 1'b0;
                    end
                end
                default: r_cur_ok <= r_cur_ok;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_oor <= !in_table(rd_idx);
        if (push) begin
            r_out      <= r_pend;
            r_out_last <= push_last;
        end
        if (dec_acc) begin
            r_bits  <= in_byte;
            r_left  <= sat_count;
            r_final <= s_axis_tlast;
        end
        if (r_state == S_ADDR) begin
            // drop the consumed bit
            r_next <= next_idx;
            r_bits <= {r_bits[BYTE_W-2:0], 1'b0};
            r_left <= r_left - CNT_W'(1);
        end
        if (r_state == S_LOAD || (r_state == S_TEST && !nent.leaf)) begin
            r_cur <= nent;
        end
        if (r_state == S_TEST && nent.leaf && !(r_pend_v && !slot_free)) begin
            r_pend.symbol <= nent.symbol;
            r_pend.status <= STATUS_SYMBOL;
        end
        if (r_state == S_END && fail && !(r_pend_v && !slot_free)) begin
            r_pend.symbol <= '0;
            r_pend.status <= STATUS_DAMAGED;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.symbol;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: rtl/core/htbd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the Huffman tree walk decoder, bound to the top level.
// Depends on htbd_pkg.
module htbd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [htbd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready
);

    import htbd_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // damaged-data word closes the input and carries symbol zero
    a_damaged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == STATUS_DAMAGED) |->
            m_axis_tlast && (m_axis_tdata == '0))
        else $error("damaged-data word malformed");

    // config and stream words are never taken together
    a_one_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_valid && o_cfg_ready && s_axis_tvalid && s_axis_tready))
        else $error("config and stream word accepted in one cycle");

    // a decode word busies the walk
    a_decode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_DECODE) |=>
            !s_axis_tready && !o_cfg_ready)
        else $error("input taken while walk in progress");

    // a load word keeps the decoder idle
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_LOAD) |=>
            o_cfg_ready)
        else $error("load word did not return to idle");

endmodule

bind huffman_tree_bit_decoder_top htbd_checker u_htbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);
